FILE: hdl/wavhp_pkg.sv
`default_nettype none

package wavhp_pkg;

  localparam logic [31:0] ID_RIFF = 32'h5249_4646;
  localparam logic [31:0] ID_WAVE = 32'h5741_5645;
  localparam logic [31:0] ID_FMT  = 32'h666d_7420;
  localparam logic [31:0] ID_DATA = 32'h6461_7461;
  localparam logic [31:0] FMT_MIN = 32'd16;

  localparam logic [7:0]  MAX_CHUNKS_RESET   = 8'd20;
  localparam logic [15:0] MAX_CHANNELS_RESET = 16'd2;
  localparam logic [7:0]  SEEN_MAX           = 8'd255;

  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHUNKS   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CHANNELS = 1'd1;

  typedef enum logic [3:0] {
    P_RIFF,
    P_RSIZE,
    P_WAVE,
    P_CID,
    P_FSIZE,
    P_OSIZE,
    P_DSIZE,
    P_FTAG,
    P_FCH,
    P_FRATE,
    P_FBRATE,
    P_FALIGN,
    P_FBITS,
    P_SKIP
  } phase_e;

  typedef enum logic [1:0] {
    R_NONE,
    R_OK,
    R_FAIL
  } rslt_e;

  typedef struct packed {
    logic        failed;
    logic [15:0] channels;
    logic [31:0] sample_rate;
    logic [15:0] sample_bits;
    logic [31:0] data_length;
  } result_t;

endpackage

`default_nettype wire

FILE: hdl/wavhp_core.sv
`default_nettype none

module wavhp_core (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      accept_i,
  input  wire  [7:0]               data_byte_i,
  input  wire                      first_byte_i,
  input  wire                      last_byte_i,
  input  wire  [7:0]               max_chunks_i,
  input  wire  [15:0]              max_channels_i,
  output logic                     res_valid_o,
  output wavhp_pkg::result_t       res_o
);
  import wavhp_pkg::*;

  phase_e      phase_q, phase_d, b_phase;
  logic [1:0]  bif_q, bif_d, b_bif, bif_inc;
  logic [31:0] shift_q, shift_d, b_shift, shift_big, shift_lit, padded;
  logic [31:0] left_q, left_d, b_left, left_m16, left_dec;
  logic [7:0]  seen_q, seen_d, b_seen;
  logic [15:0] hch_q, hch_d, b_hch;
  logic [31:0] hrate_q, hrate_d, b_hrate;
  logic [15:0] hbits_q, hbits_d, b_hbits;
  logic        fin_q, fin_d, b_fin;
  logic        last4, last2;
  rslt_e       rslt;

  always_comb begin
    if (first_byte_i) begin
      b_phase = P_RIFF;
      b_bif   = 2'd0;
      b_shift = '0;
      b_left  = '0;
      b_seen  = '0;
      b_hch   = '0;
      b_hrate = '0;
      b_hbits = '0;
      b_fin   = 1'b0;
    end else begin
      b_phase = phase_q;
      b_bif   = bif_q;
      b_shift = shift_q;
      b_left  = left_q;
      b_seen  = seen_q;
      b_hch   = hch_q;
      b_hrate = hrate_q;
      b_hbits = hbits_q;
      b_fin   = fin_q;
    end

    shift_big = {b_shift[23:0], data_byte_i};
    shift_lit = {data_byte_i, b_shift[31:8]};
    last4     = (b_bif == 2'd3);
    last2     = (b_bif != 2'd0);
    bif_inc   = b_bif + 2'd1;
    padded    = (shift_lit[0] && (shift_lit != '1)) ? shift_lit + 32'd1 : shift_lit;
    left_m16  = b_left - FMT_MIN;
    left_dec  = (b_left != '0) ? b_left - 32'd1 : b_left;

    phase_d = b_phase;
    bif_d   = b_bif;
    shift_d = b_shift;
    left_d  = b_left;
    seen_d  = b_seen;
    hch_d   = b_hch;
    hrate_d = b_hrate;
    hbits_d = b_hbits;
    fin_d   = b_fin;
    rslt    = R_NONE;

    if (!b_fin) begin
      case (b_phase)
        P_RIFF, P_WAVE: begin
          shift_d = shift_big;
          bif_d   = last4 ? 2'd0 : bif_inc;
          if (last4) begin
            if (shift_big != ((b_phase == P_RIFF) ? ID_RIFF : ID_WAVE)) begin
              rslt = R_FAIL;
            end else begin
              phase_d = (b_phase == P_RIFF) ? P_RSIZE : P_CID;
            end
          end
        end
        P_RSIZE, P_FBRATE: begin
          shift_d = shift_lit;
          bif_d   = last4 ? 2'd0 : bif_inc;
          if (last4) begin
            phase_d = (b_phase == P_RSIZE) ? P_WAVE : P_FALIGN;
          end
        end
        P_CID: begin
          if ((b_bif == 2'd0) && (b_seen >= max_chunks_i)) begin
            rslt = R_FAIL;
          end else begin
            shift_d = shift_big;
            bif_d   = last4 ? 2'd0 : bif_inc;
            if (last4) begin
              if (b_seen != SEEN_MAX) begin
                seen_d = b_seen + 8'd1;
              end
              if (shift_big == ID_FMT) begin
                phase_d = P_FSIZE;
              end else if (shift_big == ID_DATA) begin
                phase_d = P_DSIZE;
              end else begin
                phase_d = P_OSIZE;
              end
            end
          end
        end
        P_OSIZE: begin
          shift_d = shift_lit;
          bif_d   = last4 ? 2'd0 : bif_inc;
          if (last4) begin
            left_d  = padded;
            phase_d = (padded != '0) ? P_SKIP : P_CID;
          end
        end
        P_FSIZE: begin
          shift_d = shift_lit;
          bif_d   = last4 ? 2'd0 : bif_inc;
          if (last4) begin
            left_d = padded;
            if (padded < FMT_MIN) begin
              rslt = R_FAIL;
            end else begin
              phase_d = P_FTAG;
            end
          end
        end
        P_DSIZE: begin
          shift_d = shift_lit;
          bif_d   = last4 ? 2'd0 : bif_inc;
          if (last4) begin
            rslt = R_OK;
          end
        end
        P_FTAG: begin
          shift_d = shift_lit;
          bif_d   = last2 ? 2'd0 : bif_inc;
          if (last2) begin
            if (shift_lit[31:16] != 16'd1) begin
              rslt = R_FAIL;
            end else begin
              phase_d = P_FCH;
            end
          end
        end
        P_FCH: begin
          shift_d = shift_lit;
          bif_d   = last2 ? 2'd0 : bif_inc;
          if (last2) begin
            hch_d = shift_lit[31:16];
            if (shift_lit[31:16] > max_channels_i) begin
              rslt = R_FAIL;
            end else begin
              phase_d = P_FRATE;
            end
          end
        end
        P_FRATE: begin
          shift_d = shift_lit;
          bif_d   = last4 ? 2'd0 : bif_inc;
          if (last4) begin
            hrate_d = shift_lit;
            phase_d = P_FBRATE;
          end
        end
        P_FALIGN: begin
          shift_d = shift_lit;
          bif_d   = last2 ? 2'd0 : bif_inc;
          if (last2) begin
            phase_d = P_FBITS;
          end
        end
        P_FBITS: begin
          shift_d = shift_lit;
          bif_d   = last2 ? 2'd0 : bif_inc;
          if (last2) begin
            hbits_d = shift_lit[31:16];
            left_d  = left_m16;
            phase_d = (left_m16 != '0) ? P_SKIP : P_CID;
          end
        end
        P_SKIP: begin
          left_d = left_dec;
          if (left_dec == '0) begin
            phase_d = P_CID;
          end
        end
        default: begin
          phase_d = P_CID;
        end
      endcase

      if ((rslt == R_NONE) && last_byte_i) begin
        rslt = R_FAIL;
      end
      if (rslt != R_NONE) begin
        fin_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= P_RIFF;
      bif_q   <= '0;
      shift_q <= '0;
      left_q  <= '0;
      seen_q  <= '0;
      hch_q   <= '0;
      hrate_q <= '0;
      hbits_q <= '0;
      fin_q   <= 1'b0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      bif_q   <= bif_d;
      shift_q <= shift_d;
      left_q  <= left_d;
      seen_q  <= seen_d;
      hch_q   <= hch_d;
      hrate_q <= hrate_d;
      hbits_q <= hbits_d;
      fin_q   <= fin_d;
    end
  end

  assign res_valid_o       = accept_i && (rslt != R_NONE);
  assign res_o.failed      = (rslt == R_FAIL);
  assign res_o.channels    = hch_d;
  assign res_o.sample_rate = hrate_d;
  assign res_o.sample_bits = hbits_d;
  assign res_o.data_length = (rslt == R_OK) ? shift_d : '0;

  a_result_sets_finished : assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> fin_q)
    else $error("result given without marking the file finished");

  a_finished_is_silent : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_q && accept_i && !first_byte_i) |-> !res_valid_o)
    else $error("second result for one file");

  a_skip_has_bytes : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == P_SKIP) |-> (left_q != '0))
    else $error("skip phase with no bytes left");

endmodule

`default_nettype wire

FILE: hdl/wavhp_out.sv
`default_nettype none

module wavhp_out (
  input  wire                      clk_i,
  input  wire                      rst_ni,
  input  wire                      push_i,
  input  wire wavhp_pkg::result_t  push_data_i,
  output logic                     space_o,
  output logic                     out_valid_o,
  input  wire                      out_ready_i,
  output wavhp_pkg::result_t       out_data_o
);
  import wavhp_pkg::*;

  logic    out_valid_q, out_valid_d;
  logic    skid_valid_q, skid_valid_d;
  result_t out_q, out_d;
  result_t skid_q, skid_d;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    out_d        = out_q;
    skid_d       = skid_q;
    if (skid_valid_q) begin
      if (out_ready_i) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end
    end else if (push_i) begin
      if (!out_valid_q || out_ready_i) begin
        out_d       = push_data_i;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = push_data_i;
        skid_valid_d = 1'b1;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign space_o     = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_skid_behind_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_valid_q |-> out_valid_q)
    else $error("skid word held while output is empty");

  a_stall_fills_skid : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && out_valid_q && !out_ready_i && !skid_valid_q) |=> skid_valid_q)
    else $error("word pushed during stall was dropped");

  a_skid_refills_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_valid_q && out_ready_i) |=> (out_valid_q && !skid_valid_q))
    else $error("skid word not moved to output");

endmodule

`default_nettype wire

FILE: hdl/wav_header_parser.sv
// A result is formed combinationally from the byte that completes it and is registered in the output stage.
// Throughput: one byte per cycle while in_ready_o is high; the parse state updates once per accepted byte.
// A two-word output stage keeps input accepted while one result waits to be taken; input stalls while two wait.
// Reset (rst_ni low, asynchronous) restarts the parse expecting "RIFF", empties the
// output stage and sets max_chunks to 20 and max_channels to 2.
`default_nettype none

module wav_header_parser (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  wire                                   in_valid_i,
  output logic                                  in_ready_o,
  input  wire  [7:0]                            data_byte_i,
  input  wire                                   first_byte_i,
  input  wire                                   last_byte_i,
  output logic                                  out_valid_o,
  input  wire                                   out_ready_i,
  output logic                                  failed_o,
  output logic [15:0]                           channels_o,
  output logic [31:0]                           sample_rate_o,
  output logic [15:0]                           sample_bits_o,
  output logic [31:0]                           data_length_o,
  input  wire                                   cfg_we_i,
  input  wire  [wavhp_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  wire  [wavhp_pkg::CFG_DATA_W-1:0]      cfg_data_i
);
  import wavhp_pkg::*;

  logic [7:0]  max_chunks_q;
  logic [15:0] max_channels_q;
  logic        accept;
  logic        res_valid;
  logic        space;
  result_t     res;
  result_t     out_data;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_chunks_q   <= MAX_CHUNKS_RESET;
      max_channels_q <= MAX_CHANNELS_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MAX_CHUNKS:   max_chunks_q   <= cfg_data_i[7:0];
        CFG_MAX_CHANNELS: max_channels_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = space;
  assign accept     = in_valid_i && space;

  wavhp_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .accept_i       (accept),
    .data_byte_i    (data_byte_i),
    .first_byte_i   (first_byte_i),
    .last_byte_i    (last_byte_i),
    .max_chunks_i   (max_chunks_q),
    .max_channels_i (max_channels_q),
    .res_valid_o    (res_valid),
    .res_o          (res)
  );

  wavhp_out u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res_valid),
    .push_data_i (res),
    .space_o     (space),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data)
  );

  assign failed_o      = out_data.failed;
  assign channels_o    = out_data.channels;
  assign sample_rate_o = out_data.sample_rate;
  assign sample_bits_o = out_data.sample_bits;
  assign data_length_o = out_data.data_length;

endmodule

`default_nettype wire
